// ===== design/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and trig/palette helpers of the grid raycaster.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_SIZE_DEF   = 16;
    localparam int MAX_STEPS_DEF  = 1024;
    localparam int ANGLE_BITS_DEF = 12;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [9:0]  VIEW_COLS_RST      = 10'd740;
    localparam logic [9:0]  SCREEN_HEIGHT_RST  = 10'd600;
    localparam logic [11:0] FIELD_OF_VIEW_RST  = 12'd1365;

    localparam logic [30:0] RECIP_MAX = 31'h7FFF_FFFF;
    localparam logic [23:0] OUTSIDE_COLOR = 24'hFF00FF;

    typedef enum logic [1:0] {
        REG_VIEW_COLS      = 2'd0,
        REG_SCREEN_HEIGHT  = 2'd1,
        REG_FIELD_OF_VIEW  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  tile_value;
        logic [9:0]  column;
        logic [9:0]  start_column;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] view_angle;
    } t_cmd;

    typedef struct packed {
        logic [10:0] screen_column;
        logic [9:0]  wall_height;
        logic [23:0] wall_color;
        logic        hit_x_side;
    } t_res;

    typedef struct packed {
        logic [9:0]  view_cols;
        logic [9:0]  screen_height;
        logic [11:0] field_of_view;
    } t_cfg;

    // quarter-wave sine, unsigned Q1.14
    localparam logic [14:0] SINE_Q14 [17] = '{
        15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102,
        15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137,
        15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

    function automatic logic signed [15:0] sine16(input logic [15:0] phase);
        logic [1:0]  q;
        logic [14:0] w;
        logic [4:0]  idx;
        logic [4:0]  idx_n;
        logic [9:0]  frac;
        logic [10:0] diff;
        logic [20:0] prod;
        logic [14:0] v;
        q = phase[15:14];
        w = {1'b0, phase[13:0]};
        if (q[0]) begin
            w = 15'h4000 - w;
        end
        idx   = w[14:10];
        idx_n = idx + 5'd1;
        frac  = w[9:0];
        if (idx >= 5'd16) begin
            v = 15'd16384;
        end else begin
            diff = 11'(SINE_Q14[idx_n] - SINE_Q14[idx]);
            prod = diff * frac;
            v = SINE_Q14[idx] + 15'(prod >> 10);
        end
        return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic [23:0] palette(input logic [3:0] tile, input logic shade);
        logic [23:0] c;
        unique case (tile)
            4'd1:    c = shade ? 24'hDDDDDD : 24'hFFFFFF;
            4'd2:    c = shade ? 24'hDD0000 : 24'hFF0000;
            4'd3:    c = shade ? 24'h00DD00 : 24'h00FF00;
            4'd4:    c = shade ? 24'h0000DD : 24'h0000FF;
            4'd5:    c = shade ? 24'hDD00DD : 24'hFF00FF;
            4'd6:    c = shade ? 24'h333333 : 24'h444444;
            default: c = OUTSIDE_COLOR;
        endcase
        return c;
    endfunction

endpackage

// ===== design/grc_stream_if.sv =====
// ----------------------------------------------------------------------------
// grc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface grc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/grc_cfg.sv =====
// ----------------------------------------------------------------------------
// grc_cfg
// APB register bank: view column count, screen height and field of view.
// ----------------------------------------------------------------------------
module grc_cfg import grc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_cols      <= VIEW_COLS_RST;
            r_cfg.screen_height  <= SCREEN_HEIGHT_RST;
            r_cfg.field_of_view  <= FIELD_OF_VIEW_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_VIEW_COLS:      r_cfg.view_cols      <= pwdata[9:0];
                REG_SCREEN_HEIGHT:  r_cfg.screen_height  <= pwdata[9:0];
                REG_FIELD_OF_VIEW:  r_cfg.field_of_view  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VIEW_COLS:      prdata = APB_DATA_W'(r_cfg.view_cols);
            REG_SCREEN_HEIGHT:  prdata = APB_DATA_W'(r_cfg.screen_height);
            REG_FIELD_OF_VIEW:  prdata = APB_DATA_W'(r_cfg.field_of_view);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== design/grc_map.sv =====
// ----------------------------------------------------------------------------
// grc_map
// Tile map memory, one write and one registered read port, cleared after reset.
// ----------------------------------------------------------------------------
module grc_map #(
    parameter int MAP_SIZE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0] i_waddr,
    input  logic [3:0]                          i_wdata,
    input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0] i_raddr,
    output logic [3:0]                          o_rdata,
    output logic                                o_clearing
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [3:0]    r_mem [DEPTH];
    logic [3:0]    r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [3:0]    wdata;

    assign o_clearing = r_clearing;
    assign o_rdata    = r_rdata;

    // clear sweep owns the write port until every entry is zero
    assign we    = r_clearing || i_we;
    assign waddr = r_clearing ? r_clr_addr : i_waddr;
    assign wdata = r_clearing ? 4'd0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div #(
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial  = {r_rem, r_quo[DW-1]};
    assign diff   = trial - {1'b0, r_den};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out of the top of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

endmodule

// ===== design/grid_raycast_column.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column
// A map write goes straight to the tile map. A cast runs the angle, ray and
// reciprocal divisions, walks the map cells, then the distance and height
// divisions and registers its column; a division is skipped when its divisor
// would be zero (divider width DW = 33 at the default map size).
// Throughput: one command in flight, the next taken once the column is registered. Reset: map swept to zero.
// ----------------------------------------------------------------------------
module grid_raycast_column import grc_pkg::*; #(
    parameter int MAP_SIZE   = MAP_SIZE_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    grc_stream_if.sink            i_cmd,
    grc_stream_if.source          o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW   = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int CW   = $clog2(((MAP_SIZE > 16) ? MAP_SIZE : 16) + 1) + 1;
    localparam int NUMW = ((CW + 12 > 17) ? CW + 12 : 17) + 1;
    localparam int DW   = NUMW + 14;
    localparam int STW  = $clog2(MAX_STEPS + 1);
    localparam int SDW  = 32 + STW;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_ANG_MUL  = 14'b00000000000010,
        S_ANG_DIV  = 14'b00000000000100,
        S_TRIG     = 14'b00000000001000,
        S_RX_DIV   = 14'b00000000010000,
        S_RY_DIV   = 14'b00000000100000,
        S_SIDE     = 14'b00000001000000,
        S_WALK_RD  = 14'b00000010000000,
        S_WALK_CHK = 14'b00000100000000,
        S_NUM      = 14'b00001000000000,
        S_DIST_DIV = 14'b00010000000000,
        S_H_DIV    = 14'b00100000000000,
        S_FIN      = 14'b01000000000000,
        S_SPARE    = 14'b10000000000000
    } t_state;

    t_cfg cfg;
    t_cmd cmd;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   r_div_run;
    t_res   r_res;

    logic [9:0]             r_col;
    logic [9:0]             r_start;
    logic [15:0]            r_px;
    logic [15:0]            r_py;
    logic [11:0]            r_view;
    logic [21:0]            r_prod;
    logic [ANGLE_BITS-1:0]  r_ang;
    logic signed [15:0]     r_dx;
    logic signed [15:0]     r_dy;
    logic [30:0]            r_ddx;
    logic [30:0]            r_ddy;
    logic [SDW-1:0]         r_sdx;
    logic [SDW-1:0]         r_sdy;
    logic signed [CW-1:0]   r_mx;
    logic signed [CW-1:0]   r_my;
    logic                   r_xside;
    logic [STW-1:0]         r_steps;
    logic                   r_cell_in;
    logic [3:0]             r_cell;
    logic [NUMW-1:0]        r_an;
    logic [14:0]            r_dnorm;
    logic [9:0]             r_height;

    logic            cmd_acc;
    logic            out_free;
    logic            clearing;
    logic            map_we;
    logic [AW-1:0]   map_waddr;
    logic [AW-1:0]   map_raddr;
    logic [3:0]      map_rdata;
    logic            div_start;
    logic            div_done;
    logic            div_take;
    logic [DW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic [DW-1:0]   div_quo;
    logic [9:0]      vw_eff;
    logic [15:0]     phase;
    logic [14:0]     adx;
    logic [14:0]     ady;
    logic            in_map;
    logic            walk_stop;
    logic [12:0]     fx;
    logic [12:0]     fy;
    logic [43:0]     px_prod;
    logic [43:0]     py_prod;
    logic signed [NUMW-1:0] num_v;
    logic signed [CW-1:0]   sel_cell;
    logic [15:0]            sel_pos;
    logic [12:0]            sel_off;
    logic signed [15:0]     sel_d;

    assign cmd     = i_cmd.payload;
    assign cmd_acc = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && !clearing;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

    grc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign map_we = cmd_acc && (t_opcode'(cmd.opcode) == OP_WRITE)
                 && (int'(cmd.cell_x) < MAP_SIZE) && (int'(cmd.cell_y) < MAP_SIZE);
    assign map_waddr = AW'(int'(cmd.cell_y) * MAP_SIZE + int'(cmd.cell_x));
    assign in_map = (r_mx >= 0) && (r_mx < $signed(CW'(MAP_SIZE)))
                 && (r_my >= 0) && (r_my < $signed(CW'(MAP_SIZE)));
    assign map_raddr = AW'(int'(r_my) * MAP_SIZE + int'(r_mx));

    grc_map #(.MAP_SIZE(MAP_SIZE)) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (map_we),
        .i_waddr    (map_waddr),
        .i_wdata    (cmd.tile_value),
        .i_raddr    (map_raddr),
        .o_rdata    (map_rdata),
        .o_clearing (clearing)
    );

    grc_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign div_take = r_div_run && div_done;
    assign vw_eff   = (cfg.view_cols == 10'd0) ? 10'd1 : cfg.view_cols;
    assign phase    = 16'(r_ang) << (16 - ANGLE_BITS);
    assign adx      = 15'(r_dx < 0 ? -r_dx : r_dx);
    assign ady      = 15'(r_dy < 0 ? -r_dy : r_dy);

    // a ray stops on a wall, on leaving the map or when the step budget is spent
    assign walk_stop = !r_cell_in || (map_rdata != 4'd0) || (r_steps == STW'(MAX_STEPS));

    // fraction of the first cell still to cross along each axis
    assign fx = (r_dx > 0) ? 13'd4096 - 13'(r_px[11:0])
              : (r_dx < 0) ? 13'(r_px[11:0]) : 13'd2048;
    assign fy = (r_dy > 0) ? 13'd4096 - 13'(r_py[11:0])
              : (r_dy < 0) ? 13'(r_py[11:0]) : 13'd2048;
    assign px_prod = fx * r_ddx;
    assign py_prod = fy * r_ddy;

    assign sel_cell = r_xside ? r_mx : r_my;
    assign sel_pos  = r_xside ? r_px : r_py;
    assign sel_d    = r_xside ? r_dx : r_dy;
    assign sel_off  = (sel_d > 0) ? 13'd0 : (sel_d < 0) ? 13'd4096 : 13'd2048;
    assign num_v    = (NUMW'(sel_cell) <<< 12) - $signed(NUMW'(sel_pos))
                    + $signed(NUMW'(sel_off));

    always_comb begin
        unique case (r_state)
            S_ANG_DIV: begin
                div_num = DW'(r_prod);
                div_den = DW'(vw_eff);
            end
            S_RX_DIV: begin
                div_num = DW'(32'h4000_0000);
                div_den = DW'(adx);
            end
            S_RY_DIV: begin
                div_num = DW'(32'h4000_0000);
                div_den = DW'(ady);
            end
            S_DIST_DIV: begin
                div_num = DW'(r_an) << 14;
                div_den = DW'(r_dnorm);
            end
            S_H_DIV: begin
                div_num = DW'(cfg.screen_height) << 12;
                div_den = div_quo;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc && (t_opcode'(cmd.opcode) == OP_CAST)) begin
                    n_state = S_ANG_MUL;
                end
            end
            S_ANG_MUL: n_state = S_ANG_DIV;
            S_ANG_DIV: begin
                if (!r_div_run) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: n_state = S_RX_DIV;
            S_RX_DIV: begin
                if (r_dx == 16'sd0) begin
                    n_state = S_RY_DIV;
                end else if (!r_div_run) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    n_state = S_RY_DIV;
                end
            end
            S_RY_DIV: begin
                if (r_dy == 16'sd0) begin
                    n_state = S_SIDE;
                end else if (!r_div_run) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    n_state = S_SIDE;
                end
            end
            S_SIDE:     n_state = S_WALK_RD;
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: n_state = walk_stop ? S_NUM : S_WALK_RD;
            S_NUM:      n_state = S_DIST_DIV;
            S_DIST_DIV: begin
                if (r_dnorm == 15'd0) begin
                    n_state = S_FIN;
                end else if (!r_div_run) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    n_state = (div_quo == '0) ? S_FIN : S_H_DIV;
                end
            end
            S_H_DIV: begin
                // the distance quotient is still held by the divider at start
                if (!r_div_run) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_start) begin
                r_div_run <= 1'b1;
            end else if (div_done) begin
                r_div_run <= 1'b0;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_col   <= cmd.column;
            r_start <= cmd.start_column;
            r_px    <= cmd.pos_x;
            r_py    <= cmd.pos_y;
            r_view  <= cmd.view_angle;
        end
        unique case (r_state)
            S_ANG_MUL: r_prod <= r_col * cfg.field_of_view;
            S_ANG_DIV: begin
                if (div_take) begin
                    r_ang <= ANGLE_BITS'(div_quo + DW'(r_view)
                                         - DW'(cfg.field_of_view >> 1));
                end
            end
            S_TRIG: begin
                r_dx <= sine16(phase + 16'h4000);
                r_dy <= sine16(phase);
            end
            S_RX_DIV: begin
                if (r_dx == 16'sd0) begin
                    r_ddx <= RECIP_MAX;
                end else if (div_take) begin
                    r_ddx <= 31'(div_quo);
                end
            end
            S_RY_DIV: begin
                if (r_dy == 16'sd0) begin
                    r_ddy <= RECIP_MAX;
                end else if (div_take) begin
                    r_ddy <= 31'(div_quo);
                end
            end
            S_SIDE: begin
                r_sdx   <= SDW'(px_prod >> 12);
                r_sdy   <= SDW'(py_prod >> 12);
                r_mx    <= $signed(CW'(r_px[15:12]));
                r_my    <= $signed(CW'(r_py[15:12]));
                r_xside <= 1'b0;
                r_steps <= '0;
            end
            S_WALK_RD: r_cell_in <= in_map;
            S_WALK_CHK: begin
                if (walk_stop) begin
                    r_cell <= map_rdata;
                end else begin
                    r_steps <= r_steps + STW'(1);
                    if (r_sdx < r_sdy) begin
                        r_sdx   <= r_sdx + SDW'(r_ddx);
                        r_xside <= 1'b1;
                        if (r_dx > 0) begin
                            r_mx <= r_mx + CW'(1);
                        end else if (r_dx < 0) begin
                            r_mx <= r_mx - CW'(1);
                        end
                    end else begin
                        r_sdy   <= r_sdy + SDW'(r_ddy);
                        r_xside <= 1'b0;
                        if (r_dy > 0) begin
                            r_my <= r_my + CW'(1);
                        end else if (r_dy < 0) begin
                            r_my <= r_my - CW'(1);
                        end
                    end
                end
            end
            S_NUM: begin
                r_an    <= num_v[NUMW-1] ? NUMW'(-num_v) : NUMW'(num_v);
                r_dnorm <= r_xside ? adx : ady;
            end
            S_DIST_DIV: begin
                if (r_dnorm == 15'd0) begin
                    r_height <= 10'd0;
                end else if (div_take && (div_quo == '0)) begin
                    r_height <= cfg.screen_height;
                end
            end
            S_H_DIV: begin
                if (div_take) begin
                    r_height <= (div_quo > DW'(cfg.screen_height)) ? cfg.screen_height
                                                                   : div_quo[9:0];
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_res.screen_column <= 11'(r_start) + 11'(r_col);
                    r_res.wall_height   <= r_height;
                    r_res.wall_color    <= r_cell_in ? palette(r_cell, r_xside)
                                                     : OUTSIDE_COLOR;
                    r_res.hit_x_side    <= r_xside;
                end
            end
            default: ;
        endcase
    end

endmodule
